/* rtl/core/pfm_pkg.sv */
// fm voice engine package: codes, field widths, reset values and the
// quarter-wave sine generator used to build the sine rom at elaboration
// no dependencies
`default_nettype none

package pfm_pkg;

   // field widths
   localparam int OP_W        = 2;
   localparam int KEY_W       = 8;
   localparam int STEP_W      = 23;
   localparam int RATIO_W     = 16;
   localparam int DEPTH_W     = 23;
   localparam int WAVE_SEL_W  = 2;
   localparam int SAMPLE_W    = 18;
   localparam int WAVE_W      = 17;
   localparam int QSINE_W     = 15;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 23;

   // default parameter values
   localparam int VOICE_COUNT_DEF     = 8;
   localparam int PHASE_BITS_DEF      = 24;
   localparam int SINE_TABLE_BITS_DEF = 8;

   // request op codes
   localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
   localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
   localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;

   // waveform codes
   localparam logic [WAVE_SEL_W-1:0] WAVE_SINE  = 2'd0;
   localparam logic [WAVE_SEL_W-1:0] WAVE_RAMP  = 2'd1;
   localparam logic [WAVE_SEL_W-1:0] WAVE_PULSE = 2'd2;
   localparam logic [WAVE_SEL_W-1:0] WAVE_TRI   = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FM_ENABLE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FM_HARMONIC = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARRIER_WAV = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOD_WAVE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOD_FIX_INC = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOD_RATIO   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOD_DEPTH   = 3'd6;

   // register reset values
   localparam logic [STEP_W-1:0]  MOD_FIX_INC_RST = 23'd7609;
   localparam logic [RATIO_W-1:0] MOD_RATIO_RST   = 16'd256;
   localparam logic [DEPTH_W-1:0] MOD_DEPTH_RST   = 23'd534035;

   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // round(16384 * sin(pi/2 * k / 2^qbits)), taylor series to x^9 in q30
   function automatic logic [QSINE_W-1:0] quarter_sine(input longint k, input int qbits);
      longint x;
      longint x2;
      longint t;
      longint s;
      longint r;
      x  = (HALF_PI_Q30 * k) >>> qbits;
      x2 = (x * x) >>> 30;
      t  = x;
      s  = x;
      t  = ((t * x2) >>> 30) / 6;
      s  = s - t;
      t  = ((t * x2) >>> 30) / 20;
      s  = s + t;
      t  = ((t * x2) >>> 30) / 42;
      s  = s - t;
      t  = ((t * x2) >>> 30) / 72;
      s  = s + t;
      if (s < 0) begin
         s = 0;
      end
      r = (s + 32768) >>> 16;
      return r[QSINE_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/pfm_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module pfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/polyphonic_fm_voice_engine.sv */
// polyphonic two-operator fm voice engine, top level
// depends on pfm_pkg and pfm_ram
`default_nettype none

// A request is a sample tick, a note on or a note off; only a tick returns a
// response, one signed sample that is half the sum of the active voices. One
// sequencer walks the voices one at a time through a shared phase adder, a
// shared waveform unit (sine rom, saw, square, triangle) and a shared
// multiplier, with voice state held in single-write, single-read rams read one
// voice per step. A tick steps each active voice's carrier phase and, with
// modulation, its modulator phase, wave, depth product and phase offset, then
// adds its carrier wave to the sum. A note on or note off scans the voices
// until the key is found (all voices when it is not), and a note on then
// latches the modulator step. The request side is stalled while a request is
// in work; a finished sample waits in the output register and a following
// request is taken meanwhile. Registers are to be written by the user only
// while no request is in work; the block itself does not enforce it.
module polyphonic_fm_voice_engine #(
   parameter int VOICE_COUNT     = pfm_pkg::VOICE_COUNT_DEF,
   parameter int PHASE_BITS      = pfm_pkg::PHASE_BITS_DEF,
   parameter int SINE_TABLE_BITS = pfm_pkg::SINE_TABLE_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [pfm_pkg::OP_W-1:0]           req_op,
   input  wire logic [pfm_pkg::KEY_W-1:0]          req_key_code,
   input  wire logic [pfm_pkg::STEP_W-1:0]         req_phase_step,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [pfm_pkg::SAMPLE_W-1:0]     rsp_sample,
   input  wire logic                               csr_wr_en,
   input  wire logic [pfm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [pfm_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   import pfm_pkg::*;

   localparam int PB      = PHASE_BITS;
   localparam int STB     = SINE_TABLE_BITS;
   localparam int VW      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int QDEPTH  = 1 << (STB - 2);
   localparam int KW      = STB - 1;
   localparam int VR_W    = KEY_W + STEP_W + PB;
   localparam int EXT_W   = (PB > STEP_W) ? PB : STEP_W;
   localparam int MUL_A_W = DEPTH_W + 1;
   localparam int MUL_W   = MUL_A_W + WAVE_W;
   localparam int PROD_W  = ((PB + 14) > MUL_W) ? (PB + 14) : MUL_W;
   localparam int SUM_W   = WAVE_W + VW + 1;
   localparam logic [VW-1:0] LAST_VOICE = VW'(VOICE_COUNT - 1);
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(131071);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-131072);
   localparam logic signed [WAVE_W-1:0] WAVE_ONE = WAVE_W'(16384);

   typedef enum logic [12:0] {
      ST_IDLE     = 13'h0001,
      ST_SCAN_RD  = 13'h0002,
      ST_SCAN_CMP = 13'h0004,
      ST_ON_MUL   = 13'h0008,
      ST_ON_WR    = 13'h0010,
      ST_T_RD     = 13'h0020,
      ST_T_CAR    = 13'h0040,
      ST_T_MOD    = 13'h0080,
      ST_T_MWAV   = 13'h0100,
      ST_T_MUL    = 13'h0200,
      ST_T_OFF    = 13'h0400,
      ST_T_CWAV   = 13'h0800,
      ST_T_OUT    = 13'h1000
   } state_type;

   // quarter-wave sine rom
   logic [QSINE_W-1:0] qrom [QDEPTH+1];

   for (genvar g = 0; g <= QDEPTH; g++) begin : g_qrom
      localparam logic [QSINE_W-1:0] QVAL = quarter_sine(longint'(g), STB - 2);
      assign qrom[g] = QVAL;
   end

   // configuration registers
   logic                  fm_enable_ff;
   logic                  fm_harmonic_ff;
   logic [WAVE_SEL_W-1:0] carrier_wave_ff;
   logic [WAVE_SEL_W-1:0] mod_wave_ff;
   logic [STEP_W-1:0]     mod_fix_inc_ff;
   logic [RATIO_W-1:0]    mod_ratio_ff;
   logic [DEPTH_W-1:0]    mod_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fm_enable_ff    <= 1'b0;
         fm_harmonic_ff  <= 1'b0;
         carrier_wave_ff <= WAVE_SINE;
         mod_wave_ff     <= WAVE_SINE;
         mod_fix_inc_ff  <= MOD_FIX_INC_RST;
         mod_ratio_ff    <= MOD_RATIO_RST;
         mod_depth_ff    <= MOD_DEPTH_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FM_ENABLE:   fm_enable_ff    <= csr_wr_data[0];
            CSR_FM_HARMONIC: fm_harmonic_ff  <= csr_wr_data[0];
            CSR_CARRIER_WAV: carrier_wave_ff <= csr_wr_data[WAVE_SEL_W-1:0];
            CSR_MOD_WAVE:    mod_wave_ff     <= csr_wr_data[WAVE_SEL_W-1:0];
            CSR_MOD_FIX_INC: mod_fix_inc_ff  <= csr_wr_data[STEP_W-1:0];
            CSR_MOD_RATIO:   mod_ratio_ff    <= csr_wr_data[RATIO_W-1:0];
            CSR_MOD_DEPTH:   mod_depth_ff    <= csr_wr_data[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer and datapath registers
   state_type                 state_ff, state_in;
   logic [VW-1:0]             idx_ff, idx_in;
   logic [VW-1:0]             tgt_ff, tgt_in;
   logic [VW-1:0]             free_idx_ff, free_idx_in;
   logic                      free_found_ff, free_found_in;
   logic [VOICE_COUNT-1:0]    active_ff, active_in;
   logic [VOICE_COUNT-1:0]    cvld_ff, cvld_in;
   logic [VOICE_COUNT-1:0]    mvld_ff, mvld_in;
   logic [OP_W-1:0]           op_ff, op_in;
   logic [KEY_W-1:0]          key_ff, key_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [PB-1:0]             ph_ff, ph_in;
   logic [PB-1:0]             mph_ff, mph_in;
   logic signed [WAVE_W-1:0]  m_ff, m_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   // voice rams
   logic            vram_we;
   logic [VR_W-1:0] vram_wdata;
   logic [VR_W-1:0] vram_rdata;
   logic            cram_we;
   logic [PB-1:0]   cram_rdata;
   logic            mram_we;
   logic [PB-1:0]   mram_rdata;

   pfm_ram #(.WIDTH(VR_W), .DEPTH(VOICE_COUNT)) u_voice_ram (
      .clock   (clock),
      .wr_en   (vram_we),
      .wr_addr (tgt_ff),
      .wr_data (vram_wdata),
      .rd_addr (idx_ff),
      .rd_data (vram_rdata)
   );

   pfm_ram #(.WIDTH(PB), .DEPTH(VOICE_COUNT)) u_carrier_ram (
      .clock   (clock),
      .wr_en   (cram_we),
      .wr_addr (idx_ff),
      .wr_data (ph_in),
      .rd_addr (idx_ff),
      .rd_data (cram_rdata)
   );

   pfm_ram #(.WIDTH(PB), .DEPTH(VOICE_COUNT)) u_mod_ram (
      .clock   (clock),
      .wr_en   (mram_we),
      .wr_addr (idx_ff),
      .wr_data (mph_in),
      .rd_addr (idx_ff),
      .rd_data (mram_rdata)
   );

   logic [KEY_W-1:0]  vr_key;
   logic [STEP_W-1:0] vr_cstep;
   logic [PB-1:0]     vr_mstep;
   logic [EXT_W-1:0]  cstep_ext;
   logic [EXT_W-1:0]  fix_inc_ext;

   assign vr_key      = vram_rdata[VR_W-1 -: KEY_W];
   assign vr_cstep    = vram_rdata[PB +: STEP_W];
   assign vr_mstep    = vram_rdata[PB-1:0];
   assign cstep_ext   = EXT_W'(vr_cstep);
   assign fix_inc_ext = EXT_W'(mod_fix_inc_ff);
   assign vram_wdata  = {key_ff, step_ff, prod_ff[8 +: PB]};

   // shared phase adder
   logic [PB-1:0] add_a;
   logic [PB-1:0] add_b;
   logic [PB-1:0] add_sum;

   always_comb begin
      add_a = ph_ff;
      add_b = prod_ff[14 +: PB];
      case (state_ff)
         ST_T_CAR: begin
            add_a = cvld_ff[idx_ff] ? cram_rdata : '0;
            add_b = cstep_ext[PB-1:0];
         end
         ST_T_MOD: begin
            add_a = mvld_ff[idx_ff] ? mram_rdata : '0;
            add_b = fm_harmonic_ff ? vr_mstep : fix_inc_ext[PB-1:0];
         end
         default: ;
      endcase
   end

   assign add_sum = add_a + add_b;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [WAVE_W-1:0]  mul_b;
   logic signed [MUL_W-1:0]   mul_full;

   always_comb begin
      if (state_ff == ST_T_MUL) begin
         mul_a = $signed({1'b0, mod_depth_ff});
         mul_b = m_ff;
      end else begin
         mul_a = $signed({1'b0, step_ff});
         mul_b = $signed({1'b0, mod_ratio_ff});
      end
   end

   assign mul_full = mul_a * mul_b;
   assign prod_in  = PROD_W'(mul_full);

   // shared waveform unit
   logic [WAVE_SEL_W-1:0]    wave_sel;
   logic [PB-1:0]            wave_ph;
   logic [15:0]              wave_a;
   logic [STB-1:0]           sine_idx;
   logic [1:0]               sine_quad;
   logic [KW-1:0]            sine_r;
   logic [KW-1:0]            sine_k;
   logic [QSINE_W-1:0]       sine_mag;
   logic signed [WAVE_W-1:0] sine_val;
   logic signed [WAVE_W:0]   a_ext;
   logic signed [WAVE_W:0]   wave_wide;
   logic signed [WAVE_W-1:0] wave_out;

   assign wave_sel  = (state_ff == ST_T_MWAV) ? mod_wave_ff : carrier_wave_ff;
   assign wave_ph   = (state_ff == ST_T_MWAV) ? mph_ff : ph_ff;
   assign wave_a    = wave_ph[PB-1 -: 16];
   assign sine_idx  = wave_ph[PB-1 -: STB];
   assign sine_quad = sine_idx[STB-1 -: 2];
   assign sine_r    = KW'(sine_idx[STB-3:0]);
   assign sine_k    = sine_quad[0] ? (KW'(QDEPTH) - sine_r) : sine_r;
   assign sine_mag  = qrom[sine_k];
   assign sine_val  = sine_quad[1] ? -$signed({2'b00, sine_mag}) : $signed({2'b00, sine_mag});
   assign a_ext     = $signed({2'b00, wave_a});

   always_comb begin
      case (wave_sel)
         WAVE_SINE:  wave_wide = (WAVE_W+1)'(sine_val);
         WAVE_RAMP:  wave_wide = (a_ext >>> 1) - (WAVE_W+1)'(16384);
         WAVE_PULSE: wave_wide = (sine_val > 0) ? (WAVE_W+1)'(WAVE_ONE)
                                                : -(WAVE_W+1)'(WAVE_ONE);
         WAVE_TRI: begin
            if (wave_a < 16'd16384) begin
               wave_wide = a_ext;
            end else if (wave_a < 16'd49152) begin
               wave_wide = (WAVE_W+1)'(32768) - a_ext;
            end else begin
               wave_wide = a_ext - (WAVE_W+1)'(65536);
            end
         end
         default:    wave_wide = '0;
      endcase
   end

   assign wave_out = wave_wide[WAVE_W-1:0];

   // output halving and saturation
   logic signed [SUM_W-1:0] half;
   logic signed [SUM_W-1:0] sat_val;

   assign half    = sum_ff >>> 1;
   assign sat_val = (half > SAT_HI) ? SAT_HI : ((half < SAT_LO) ? SAT_LO : half);

   // sequencer
   logic last_voice;
   logic hit;
   logic req_take;

   assign last_voice = (idx_ff == LAST_VOICE);
   assign hit        = active_ff[idx_ff] && (vr_key == key_ff);
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      tgt_in        = tgt_ff;
      free_idx_in   = free_idx_ff;
      free_found_in = free_found_ff;
      active_in     = active_ff;
      cvld_in       = cvld_ff;
      mvld_in       = mvld_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      step_in       = step_ff;
      ph_in         = ph_ff;
      mph_in        = mph_ff;
      m_in          = m_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      vram_we       = 1'b0;
      cram_we       = 1'b0;
      mram_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in         = req_op;
               key_in        = req_key_code;
               step_in       = req_phase_step;
               idx_in        = '0;
               free_found_in = 1'b0;
               sum_in        = '0;
               case (req_op)
                  OP_TICK:     state_in = ST_T_RD;
                  OP_NOTE_ON:  state_in = ST_SCAN_RD;
                  OP_NOTE_OFF: state_in = ST_SCAN_RD;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (op_ff == OP_NOTE_ON) begin
               if (hit) begin
                  tgt_in   = idx_ff;
                  state_in = ST_ON_MUL;
               end else begin
                  if (!active_ff[idx_ff] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = idx_ff;
                  end
                  if (last_voice) begin
                     if (free_found_ff) begin
                        tgt_in = free_idx_ff;
                     end else if (!active_ff[idx_ff]) begin
                        tgt_in = idx_ff;
                     end else begin
                        tgt_in = '0;
                     end
                     state_in = ST_ON_MUL;
                  end else begin
                     idx_in   = idx_ff + VW'(1);
                     state_in = ST_SCAN_RD;
                  end
               end
            end else begin
               if (hit) begin
                  active_in[idx_ff] = 1'b0;
                  state_in          = ST_IDLE;
               end else if (last_voice) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + VW'(1);
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_ON_MUL: begin
            state_in = ST_ON_WR;
         end
         ST_ON_WR: begin
            vram_we           = 1'b1;
            active_in[tgt_ff] = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_T_RD: begin
            if (active_ff[idx_ff]) begin
               state_in = ST_T_CAR;
            end else if (last_voice) begin
               state_in = ST_T_OUT;
            end else begin
               idx_in = idx_ff + VW'(1);
            end
         end
         ST_T_CAR: begin
            ph_in           = add_sum;
            cram_we         = 1'b1;
            cvld_in[idx_ff] = 1'b1;
            state_in        = fm_enable_ff ? ST_T_MOD : ST_T_CWAV;
         end
         ST_T_MOD: begin
            mph_in          = add_sum;
            mram_we         = 1'b1;
            mvld_in[idx_ff] = 1'b1;
            state_in        = ST_T_MWAV;
         end
         ST_T_MWAV: begin
            m_in     = wave_out;
            state_in = ST_T_MUL;
         end
         ST_T_MUL: begin
            state_in = ST_T_OFF;
         end
         ST_T_OFF: begin
            ph_in    = add_sum;
            state_in = ST_T_CWAV;
         end
         ST_T_CWAV: begin
            sum_in = sum_ff + SUM_W'(wave_out);
            if (last_voice) begin
               state_in = ST_T_OUT;
            end else begin
               idx_in   = idx_ff + VW'(1);
               state_in = ST_T_RD;
            end
         end
         ST_T_OUT: begin
            // wait for the previous sample to leave
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sat_val[SAMPLE_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         tgt_ff        <= '0;
         free_idx_ff   <= '0;
         free_found_ff <= 1'b0;
         active_ff     <= '0;
         cvld_ff       <= '0;
         mvld_ff       <= '0;
         op_ff         <= OP_TICK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         tgt_ff        <= tgt_in;
         free_idx_ff   <= free_idx_in;
         free_found_ff <= free_found_in;
         active_ff     <= active_in;
         cvld_ff       <= cvld_in;
         mvld_ff       <= mvld_in;
         op_ff         <= op_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      step_ff       <= step_in;
      ph_ff         <= ph_in;
      mph_ff        <= mph_in;
      m_ff          <= m_in;
      prod_ff       <= prod_in;
      sum_ff        <= sum_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

`default_nettype wire
